// ===== hdl/i2c_master_bit_engine_unit_macros.svh =====
// ---------------------------------------------------------------------------
// I2C bit engine assertion macros
// Shared property forms for the checker of the bit engine.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define IBE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ibe_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine package
// Widths, opcodes, command classes and the words passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package ibe_pkg;

   localparam int OPCODE_W        = 3;
   localparam int BYTE_W          = 8;
   localparam int TIMEOUT_W       = 16;
   localparam int BIT_CNT_W       = 4;
   localparam int PHASE_W         = 3;
   localparam int IBE_QUEUE_DEPTH = 2;

   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 16'd250;
   localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

   localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

   typedef enum logic [4:0] {
      CMD_IDLE  = 5'b00001,
      CMD_START = 5'b00010,
      CMD_STOP  = 5'b00100,
      CMD_WRITE = 5'b01000,
      CMD_READ  = 5'b10000
   } cmd_type;

   typedef logic [PHASE_W-1:0] phase_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] data_byte;
      logic              send_nack;
      logic              sda_in;
   } entry_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic              busy_res;
      logic              cmd_done;
      logic [BYTE_W-1:0] read_byte;
      logic              nack_seen;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/ibe_if.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine channels
// Request, response and control register channels with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ibe_req_if import ibe_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   data_byte;
   logic                send_nack;
   logic                sda_in;

   modport source (output valid, opcode, data_byte, send_nack, sda_in, input ready);
   modport sink   (input valid, opcode, data_byte, send_nack, sda_in, output ready);
endinterface

interface ibe_rsp_if import ibe_pkg::*;;
   logic              valid;
   logic              ready;
   logic              scl_level;
   logic              sda_level;
   logic              busy_res;
   logic              cmd_done;
   logic [BYTE_W-1:0] read_byte;
   logic              nack_seen;

   modport source (output valid, scl_level, sda_level, busy_res, cmd_done, read_byte,
                   nack_seen, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, cmd_done, read_byte,
                   nack_seen, output ready);
endinterface

interface ibe_csr_if import ibe_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ibe_front.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine front end
// Accepts request words and classifies the opcode into a command class.
// ---------------------------------------------------------------------------
`default_nettype none

module ibe_front import ibe_pkg::*; (
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_send_nack,
   input  wire logic                req_sda_in,
   output      logic                push_valid,
   input  wire logic                push_ready,
   output      entry_type           push_entry
);

   cmd_type cmd_class;

   always_comb begin
      case (req_opcode)
         OP_START: cmd_class = CMD_START;
         OP_STOP:  cmd_class = CMD_STOP;
         OP_WRITE: cmd_class = CMD_WRITE;
         OP_READ:  cmd_class = CMD_READ;
         default:  cmd_class = CMD_IDLE;
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign push_entry.cmd       = cmd_class;
   assign push_entry.data_byte = req_data_byte;
   assign push_entry.send_nack = req_send_nack;
   assign push_entry.sda_in    = req_sda_in;

endmodule

`default_nettype wire

// ===== hdl/ibe_queue.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine queue
// Short first-in first-out buffer between the front end and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module ibe_queue import ibe_pkg::*; #(
   parameter int DEPTH = IBE_QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire entry_type in_entry,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      entry_type out_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ibe_back.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine sequencer
// Runs one bus quantum per word and holds the result word for the sink.
// ---------------------------------------------------------------------------
`default_nettype none

module ibe_back import ibe_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [TIMEOUT_W-1:0] csr_data,
   input  wire logic                 pop_valid,
   output      logic                 pop_ready,
   input  wire entry_type            pop_entry,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      result_type           rsp_word
);

   localparam phase_type SEQ_FIRST    = 3'd0;
   localparam phase_type SEQ_SECOND   = 3'd1;
   localparam phase_type SEQ_LAST     = 3'd2;

   localparam phase_type WR_BIT_SETUP = 3'd0;
   localparam phase_type WR_BIT_CLOCK = 3'd1;
   localparam phase_type WR_ACK_SETUP = 3'd2;
   localparam phase_type WR_ACK_POLL  = 3'd3;
   localparam phase_type WR_ACK_END   = 3'd4;
   localparam phase_type WR_STOP_LOW  = 3'd5;
   localparam phase_type WR_STOP_HIGH = 3'd6;
   localparam phase_type WR_STOP_END  = 3'd7;

   localparam phase_type RD_SAMPLE    = 3'd0;
   localparam phase_type RD_CLOCK_LOW = 3'd1;
   localparam phase_type RD_ACK_DRIVE = 3'd2;
   localparam phase_type RD_ACK_HIGH  = 3'd3;
   localparam phase_type RD_ACK_LOW   = 3'd4;
   localparam phase_type RD_RELEASE   = 3'd5;

   cmd_type              cmd_ff,       cmd_in;
   phase_type            phase_ff,     phase_in;
   logic [BIT_CNT_W-1:0] bit_ff,       bit_in;
   logic [BYTE_W-1:0]    shift_ff,     shift_in;
   logic [TIMEOUT_W-1:0] wait_ff,      wait_in;
   logic                 scl_ff,       scl_in;
   logic                 sda_ff,       sda_in;
   logic                 ack_mode_ff,  ack_mode_in;
   logic [BYTE_W-1:0]    held_read_ff, held_read_in;
   logic                 held_nack_ff, held_nack_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_word_ff,  rsp_word_in;
   logic                 pop;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      logic busy;
      logic fin;
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_mode_in  = ack_mode_ff;
      held_read_in = held_read_ff;
      held_nack_in = held_nack_ff;
      fin          = 1'b0;

      if (cmd_ff == CMD_IDLE && pop_entry.cmd != CMD_IDLE) begin
         cmd_in   = pop_entry.cmd;
         phase_in = SEQ_FIRST;
         bit_in   = '0;
         wait_in  = '0;
         if (pop_entry.cmd == CMD_WRITE) begin
            shift_in     = pop_entry.data_byte;
            held_nack_in = 1'b0;
         end
         if (pop_entry.cmd == CMD_READ) begin
            shift_in    = '0;
            ack_mode_in = pop_entry.send_nack;
         end
      end
      busy = (cmd_in != CMD_IDLE);

      case (cmd_in)
         CMD_START: begin
            case (phase_in)
               SEQ_FIRST: begin
                  sda_in = 1'b1; scl_in = 1'b1; phase_in = SEQ_SECOND;
               end
               SEQ_SECOND: begin
                  sda_in = 1'b0; phase_in = SEQ_LAST;
               end
               SEQ_LAST: begin
                  scl_in = 1'b0; fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
         end
         CMD_STOP: begin
            case (phase_in)
               SEQ_FIRST: begin
                  sda_in = 1'b0; phase_in = SEQ_SECOND;
               end
               SEQ_SECOND: begin
                  scl_in = 1'b1; phase_in = SEQ_LAST;
               end
               SEQ_LAST: begin
                  sda_in = 1'b1; fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
         end
         CMD_WRITE: begin
            case (phase_in)
               WR_BIT_SETUP: begin
                  sda_in = shift_in[BYTE_W-1]; scl_in = 1'b0; phase_in = WR_BIT_CLOCK;
               end
               WR_BIT_CLOCK: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[BYTE_W-2:0], 1'b0};
                  bit_in   = bit_in + BIT_CNT_W'(1);
                  phase_in = (bit_in >= BITS_PER_BYTE) ? WR_ACK_SETUP : WR_BIT_SETUP;
               end
               WR_ACK_SETUP: begin
                  scl_in = 1'b0; sda_in = 1'b1; wait_in = '0; phase_in = WR_ACK_POLL;
               end
               WR_ACK_POLL: begin
                  scl_in = 1'b1; sda_in = 1'b1;
                  if (!pop_entry.sda_in) begin
                     phase_in = WR_ACK_END;
                  end else if (wait_in >= timeout_ff) begin
                     phase_in = WR_STOP_LOW;
                  end else begin
                     wait_in = wait_in + TIMEOUT_W'(1);
                  end
               end
               WR_ACK_END: begin
                  scl_in = 1'b0; held_nack_in = 1'b0; fin = 1'b1;
               end
               WR_STOP_LOW: begin
                  scl_in = 1'b0; sda_in = 1'b0; phase_in = WR_STOP_HIGH;
               end
               WR_STOP_HIGH: begin
                  scl_in = 1'b1; phase_in = WR_STOP_END;
               end
               WR_STOP_END: begin
                  sda_in = 1'b1; held_nack_in = 1'b1; fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
         end
         CMD_READ: begin
            case (phase_in)
               RD_SAMPLE: begin
                  scl_in   = 1'b1; sda_in = 1'b1;
                  shift_in = {shift_in[BYTE_W-2:0], pop_entry.sda_in};
                  phase_in = RD_CLOCK_LOW;
               end
               RD_CLOCK_LOW: begin
                  scl_in   = 1'b0;
                  bit_in   = bit_in + BIT_CNT_W'(1);
                  phase_in = (bit_in >= BITS_PER_BYTE) ? RD_ACK_DRIVE : RD_SAMPLE;
               end
               RD_ACK_DRIVE: begin
                  sda_in = ack_mode_in; scl_in = 1'b0; phase_in = RD_ACK_HIGH;
               end
               RD_ACK_HIGH: begin
                  scl_in = 1'b1; phase_in = RD_ACK_LOW;
               end
               RD_ACK_LOW: begin
                  scl_in = 1'b0;
                  if (ack_mode_in) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = RD_RELEASE;
                  end
               end
               RD_RELEASE: begin
                  sda_in = 1'b1; fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
            if (fin) begin
               held_read_in = shift_in;
            end
         end
         default: fin = 1'b0;
      endcase

      if (fin) begin
         cmd_in   = CMD_IDLE;
         phase_in = SEQ_FIRST;
      end

      rsp_word_in.scl_level = scl_in;
      rsp_word_in.sda_level = sda_in;
      rsp_word_in.busy_res  = busy;
      rsp_word_in.cmd_done  = fin;
      rsp_word_in.read_byte = held_read_in;
      rsp_word_in.nack_seen = held_nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_IDLE;
         phase_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         wait_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_mode_ff  <= 1'b0;
         held_read_ff <= '0;
         held_nack_ff <= 1'b0;
         timeout_ff   <= ACK_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         if (pop) begin
            cmd_ff       <= cmd_in;
            phase_ff     <= phase_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            wait_ff      <= wait_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            ack_mode_ff  <= ack_mode_in;
            held_read_ff <= held_read_in;
            held_nack_ff <= held_nack_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_unit.sv =====
// An accepted word is written into the queue; its result is then registered in the sequencer's result word.
// Throughput: one word per cycle while the result side is ready; a stalled result holds the sequencer.
// A word is taken while a result waits, until the queue in front is full.
// Reset is synchronous: lines released, no command active, timeout back to 250.
// ---------------------------------------------------------------------------
// I2C bit engine top level
// Front end, word queue and bus sequencer of a bit-banged I2C master.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_unit import ibe_pkg::*; #(
   parameter int QUEUE_DEPTH = IBE_QUEUE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   ibe_req_if.sink   req_bus,
   ibe_rsp_if.source rsp_bus,
   ibe_csr_if.sink   csr_bus
);

   logic       push_valid, push_ready;
   entry_type  push_entry;
   logic       pop_valid,  pop_ready;
   entry_type  pop_entry;
   result_type rsp_word;

   ibe_front u_front (
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_opcode    (req_bus.opcode),
      .req_data_byte (req_bus.data_byte),
      .req_send_nack (req_bus.send_nack),
      .req_sda_in    (req_bus.sda_in),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   ibe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   ibe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_data  (csr_bus.data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_bus.scl_level = rsp_word.scl_level;
   assign rsp_bus.sda_level = rsp_word.sda_level;
   assign rsp_bus.busy_res  = rsp_word.busy_res;
   assign rsp_bus.cmd_done  = rsp_word.cmd_done;
   assign rsp_bus.read_byte = rsp_word.read_byte;
   assign rsp_bus.nack_seen = rsp_word.nack_seen;

endmodule

`default_nettype wire

// ===== hdl/ibe_checker.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine checker
// Port-level properties of the bit engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_engine_unit_macros.svh"

module ibe_checker import ibe_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              scl_level,
   input wire logic              sda_level,
   input wire logic              busy_res,
   input wire logic              cmd_done,
   input wire logic [BYTE_W-1:0] read_byte,
   input wire logic              nack_seen
);

   logic [7:0]        pending_ff, pending_in;
   logic              req_fire, rsp_fire;
   logic              idle_fire, rsp_stall;
   logic [BYTE_W+4:0] rsp_fields;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign idle_fire  = req_fire && (pending_ff == 8'd0);
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_fields = {scl_level, sda_level, busy_res, cmd_done, read_byte, nack_seen};

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 8'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `IBE_ASSERT_SAME(a_done_busy, clock, reset, rsp_valid && cmd_done, busy_res, "done without busy")
   `IBE_ASSERT_SAME(a_no_extra, clock, reset, rsp_valid, pending_ff != 8'd0, "result without word")
   `IBE_ASSERT_NEXT(a_latency, clock, reset, idle_fire, ##1 rsp_valid, "late result")
   `IBE_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields), "word changed")

endmodule

bind i2c_master_bit_engine_unit ibe_checker u_ibe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .scl_level (rsp_bus.scl_level),
   .sda_level (rsp_bus.sda_level),
   .busy_res  (rsp_bus.busy_res),
   .cmd_done  (rsp_bus.cmd_done),
   .read_byte (rsp_bus.read_byte),
   .nack_seen (rsp_bus.nack_seen)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// I2C bit engine testbench
// Drives bus quanta into the bit engine under random gaps and stalls, tracks
// the expected SCL/SDA levels and status with a line-level predictor, and
// compares each result word. Sweeps the ACK timeout through its extremes.
// ---------------------------------------------------------------------------
module tb import ibe_pkg::*;;

   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int WORDS_PER_SETTING = 200;
   localparam int HOLD_AFTER        = 500;
   localparam int HOLD_CYCLES       = 400;
   localparam int IDLE_LIMIT        = 5000;
   localparam int DRAIN_CYCLES      = 8;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   data_byte;
      logic                send_nack;
      logic                sda_in;
   } quantum_type;

   typedef struct {
      logic [OPCODE_W-1:0]  cmd;
      logic [3:0]           step;
      logic [BIT_CNT_W-1:0] bit_count;
      logic [BYTE_W-1:0]    shifter;
      logic [TIMEOUT_W-1:0] polls;
      logic                 scl;
      logic                 sda;
      logic                 nack_after_read;
      logic [BYTE_W-1:0]    held_read;
      logic                 held_nack;
   } bus_state_type;

   logic clock;
   logic reset;

   ibe_req_if req_bus ();
   ibe_rsp_if rsp_bus ();
   ibe_csr_if csr_bus ();

   i2c_master_bit_engine_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bus_state_type        plan_state;
   bus_state_type        line_state;
   logic [TIMEOUT_W-1:0] plan_limit;
   logic [TIMEOUT_W-1:0] line_limit;
   quantum_type          pending_q[$];
   result_type           expected_q[$];
   quantum_type          sent_word;
   result_type           want_word;

   int queued_total;
   int accepted_total;
   int matched_total;
   int results_seen;
   int mismatches;
   int command_words;
   int starts, stops, writes, reads, gave_up;
   int settings_used;
   int req_gap, req_quiet, rsp_gap, rsp_quiet;
   int hold_left;
   logic hold_rsp, hold_done;
   int stalled_cycles;

   function automatic bus_state_type bus_reset();
      bus_state_type s;
      s.cmd             = OP_TICK;
      s.step            = '0;
      s.bit_count       = '0;
      s.shifter         = '0;
      s.polls           = '0;
      s.scl             = 1'b1;
      s.sda             = 1'b1;
      s.nack_after_read = 1'b0;
      s.held_read       = '0;
      s.held_nack       = 1'b0;
      return s;
   endfunction

   function automatic result_type bus_quantum(inout bus_state_type s, input quantum_type q,
                                              input logic [TIMEOUT_W-1:0] limit);
      result_type r;
      logic       fin;
      r   = '0;
      fin = 1'b0;
      if (s.cmd == OP_TICK && q.opcode >= OP_START && q.opcode <= OP_READ) begin
         s.cmd       = q.opcode;
         s.step      = '0;
         s.bit_count = '0;
         s.polls     = '0;
         if (q.opcode == OP_WRITE) begin
            s.shifter   = q.data_byte;
            s.held_nack = 1'b0;
         end
         if (q.opcode == OP_READ) begin
            s.shifter         = '0;
            s.nack_after_read = q.send_nack;
         end
      end
      if (s.cmd != OP_TICK) begin
         r.busy_res = 1'b1;
         case (s.cmd)
            OP_START: begin
               case (s.step)
                  0: begin s.sda = 1'b1; s.scl = 1'b1; s.step = 1; end
                  1: begin s.sda = 1'b0; s.step = 2; end
                  2: begin s.scl = 1'b0; fin = 1'b1; end
                  default: fin = 1'b1;
               endcase
            end
            OP_STOP: begin
               case (s.step)
                  0: begin s.sda = 1'b0; s.step = 1; end
                  1: begin s.scl = 1'b1; s.step = 2; end
                  2: begin s.sda = 1'b1; fin = 1'b1; end
                  default: fin = 1'b1;
               endcase
            end
            OP_WRITE: begin
               case (s.step)
                  0: begin s.sda = s.shifter[BYTE_W-1]; s.scl = 1'b0; s.step = 1; end
                  1: begin
                     s.scl       = 1'b1;
                     s.shifter   = s.shifter << 1;
                     s.bit_count = s.bit_count + 1'b1;
                     s.step      = (s.bit_count >= BITS_PER_BYTE) ? 4'd2 : 4'd0;
                  end
                  2: begin s.scl = 1'b0; s.sda = 1'b1; s.polls = '0; s.step = 3; end
                  3: begin
                     s.scl = 1'b1;
                     s.sda = 1'b1;
                     if (!q.sda_in) s.step = 4;
                     else if (s.polls >= limit) s.step = 5;
                     else s.polls = s.polls + 1'b1;
                  end
                  4: begin s.scl = 1'b0; s.held_nack = 1'b0; fin = 1'b1; end
                  5: begin s.scl = 1'b0; s.sda = 1'b0; s.step = 6; end
                  6: begin s.scl = 1'b1; s.step = 7; end
                  7: begin s.sda = 1'b1; s.held_nack = 1'b1; fin = 1'b1; end
                  default: fin = 1'b1;
               endcase
            end
            OP_READ: begin
               case (s.step)
                  0: begin
                     s.scl     = 1'b1;
                     s.sda     = 1'b1;
                     s.shifter = {s.shifter[BYTE_W-2:0], q.sda_in};
                     s.step    = 1;
                  end
                  1: begin
                     s.scl       = 1'b0;
                     s.bit_count = s.bit_count + 1'b1;
                     s.step      = (s.bit_count >= BITS_PER_BYTE) ? 4'd2 : 4'd0;
                  end
                  2: begin s.sda = s.nack_after_read; s.scl = 1'b0; s.step = 3; end
                  3: begin s.scl = 1'b1; s.step = 4; end
                  4: begin
                     s.scl = 1'b0;
                     if (s.nack_after_read) fin = 1'b1;
                     else s.step = 5;
                  end
                  5: begin s.sda = 1'b1; fin = 1'b1; end
                  default: fin = 1'b1;
               endcase
               if (fin) s.held_read = s.shifter;
            end
            default: fin = 1'b1;
         endcase
         if (fin) begin
            r.cmd_done = 1'b1;
            s.cmd      = OP_TICK;
            s.step     = '0;
         end
      end
      r.scl_level = s.scl;
      r.sda_level = s.sda;
      r.read_byte = s.held_read;
      r.nack_seen = s.held_nack;
      return r;
   endfunction

   function automatic int draw_gap(inout int quiet_left);
      int pick;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic quantum_type random_word();
      quantum_type q;
      q.opcode    = OPCODE_W'($urandom_range(0, 7));
      q.data_byte = BYTE_W'($urandom_range(0, 255));
      q.send_nack = 1'($urandom_range(0, 1));
      q.sda_in    = 1'($urandom_range(0, 1));
      return q;
   endfunction

   task automatic queue_word(input quantum_type q);
      void'(bus_quantum(plan_state, q, plan_limit));
      pending_q.push_back(q);
      queued_total++;
   endtask

   task automatic queue_spare(input logic [OPCODE_W-1:0] op);
      quantum_type q;
      q        = random_word();
      q.opcode = op;
      queue_word(q);
   endtask

   // feed filler words until the command retires; fillers carry random opcodes
   task automatic queue_command(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] value,
                                input logic nack, input int high_polls);
      quantum_type q;
      int          polls_sent;
      int          first;
      first       = queued_total;
      polls_sent  = 0;
      q           = random_word();
      q.opcode    = op;
      q.data_byte = value;
      q.send_nack = nack;
      queue_word(q);
      while (plan_state.cmd != OP_TICK) begin
         q = random_word();
         if (plan_state.cmd == OP_WRITE && plan_state.step == 3) begin
            q.sda_in = (polls_sent < high_polls);
            polls_sent++;
         end
         queue_word(q);
      end
      command_words += queued_total - first;
      case (op)
         OP_START: starts++;
         OP_STOP:  stops++;
         OP_WRITE: begin
            writes++;
            if (plan_state.held_nack) gave_up++;
         end
         OP_READ:  reads++;
         default: ;
      endcase
   endtask

   task automatic queue_byte_command();
      int pick;
      int high_polls;
      pick = $urandom_range(0, 9);
      if (pick < 6) high_polls = $urandom_range(0, 3);
      else if (pick < 8) high_polls = $urandom_range(0, 12);
      else if (plan_limit <= 300) high_polls = int'(plan_limit) + 1;
      else high_polls = $urandom_range(13, 40);
      if ($urandom_range(0, 4) < 3)
         queue_command(OP_WRITE, BYTE_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), high_polls);
      else
         queue_command(OP_READ, BYTE_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 0);
   endtask

   task automatic fill_random(input int n);
      int goal;
      int pick;
      int k;
      goal = command_words + n;
      while (command_words < goal) begin
         if ($urandom_range(0, 5) == 0)
            queue_spare(($urandom_range(0, 3) == 0) ? OP_TICK :
                        OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            queue_command(OP_START, 8'h00, 1'b0, 0);
            for (k = $urandom_range(1, 4); k > 0; k--) queue_byte_command();
            queue_command(OP_STOP, 8'h00, 1'b0, 0);
         end else if (pick == 8) begin
            queue_byte_command();
         end else begin
            queue_command(($urandom_range(0, 1) != 0) ? OP_START : OP_STOP, 8'h00, 1'b0, 0);
         end
      end
   endtask

   task automatic drain();
      while (accepted_total != queued_total || matched_total != accepted_total)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic retune(input logic [TIMEOUT_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      line_limit = value;
      plan_limit = value;
      settings_used++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_q.push_back(bus_quantum(line_state, sent_word, line_limit));
            accepted_total++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               sent_word = pending_q.pop_front();
               req_bus.opcode    <= sent_word.opcode;
               req_bus.data_byte <= sent_word.data_byte;
               req_bus.send_nack <= sent_word.send_nack;
               req_bus.sda_in    <= sent_word.sda_in;
               req_bus.valid     <= 1'b1;
               req_gap = draw_gap(req_quiet);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("result word with no expectation pending");
               mismatches++;
            end else begin
               want_word = expected_q.pop_front();
               matched_total++;
               if (rsp_bus.scl_level !== want_word.scl_level) begin
                  $error("scl_level: expected %0b, got %0b", want_word.scl_level,
                         rsp_bus.scl_level);
                  mismatches++;
               end
               if (rsp_bus.sda_level !== want_word.sda_level) begin
                  $error("sda_level: expected %0b, got %0b", want_word.sda_level,
                         rsp_bus.sda_level);
                  mismatches++;
               end
               if (rsp_bus.busy_res !== want_word.busy_res) begin
                  $error("busy_res: expected %0b, got %0b", want_word.busy_res,
                         rsp_bus.busy_res);
                  mismatches++;
               end
               if (rsp_bus.cmd_done !== want_word.cmd_done) begin
                  $error("cmd_done: expected %0b, got %0b", want_word.cmd_done,
                         rsp_bus.cmd_done);
                  mismatches++;
               end
               if (rsp_bus.read_byte !== want_word.read_byte) begin
                  $error("read_byte: expected 0x%02h, got 0x%02h", want_word.read_byte,
                         rsp_bus.read_byte);
                  mismatches++;
               end
               if (rsp_bus.nack_seen !== want_word.nack_seen) begin
                  $error("nack_seen: expected %0b, got %0b", want_word.nack_seen,
                         rsp_bus.nack_seen);
                  mismatches++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap = draw_gap(rsp_quiet);
         end
      end
   end

   // hold off the result side once so the request side backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_rsp  <= 1'b0;
         hold_done <= 1'b0;
         hold_left <= 0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_rsp  <= 1'b1;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) hold_rsp <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stalled_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= IDLE_LIMIT) begin
         $display("i2c_master_bit_engine_unit verification failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = OP_TICK;
      req_bus.data_byte = '0;
      req_bus.send_nack = 1'b0;
      req_bus.sda_in    = 1'b1;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      plan_state        = bus_reset();
      line_state        = bus_reset();
      plan_limit        = ACK_TIMEOUT_RESET;
      line_limit        = ACK_TIMEOUT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_spare(OP_TICK);
      queue_spare(OP_SPARE_FIRST);
      queue_spare(OP_SPARE_FIRST + 3'd1);
      queue_spare(OP_SPARE_LAST);
      queue_command(OP_STOP, 8'h00, 1'b0, 0);
      queue_command(OP_START, 8'hFF, 1'b1, 0);
      queue_command(OP_WRITE, 8'hFF, 1'b0, 0);
      queue_command(OP_READ, 8'h00, 1'b1, 0);
      queue_command(OP_WRITE, 8'h00, 1'b1, 2);
      queue_command(OP_READ, 8'hFF, 1'b0, 0);
      queue_command(OP_STOP, 8'hFF, 1'b1, 0);
      fill_random(WORDS_PER_SETTING);
      drain();

      retune(16'd0);
      fill_random(WORDS_PER_SETTING);
      drain();
      retune(16'hFFFF);
      fill_random(WORDS_PER_SETTING);
      drain();
      retune(16'd1);
      fill_random(WORDS_PER_SETTING);
      drain();
      retune(16'd6);
      fill_random(WORDS_PER_SETTING);
      drain();
      retune(ACK_TIMEOUT_RESET);
      fill_random(WORDS_PER_SETTING);
      drain();

      if (expected_q.size() != 0) begin
         $error("%0d expected result words never arrived", expected_q.size());
         mismatches++;
      end
      $display("Sent %0d words under %0d written timeouts plus the reset value:",
               accepted_total, settings_used);
      $display("%0d starts, %0d stops, %0d writes, %0d reads; %0d writes gave up on ACK.",
               starts, stops, writes, reads, gave_up);
      $display("%0d result words checked, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("i2c_master_bit_engine_unit verification clean");
      else
         $display("i2c_master_bit_engine_unit verification failed");
      $finish;
   end

endmodule
